// ===== hw/rtl/hgni_pkg.sv =====
// ============================================================================
// hgni_pkg
// Shared constants and types for the hex board neighbor index block.
// ============================================================================
package hgni_pkg;

    // Field and register widths
    localparam int REG_W          = 9;
    localparam int TILE_W         = 16;
    localparam int POS_W          = 3;
    localparam int CFG_INDEX_W    = 1;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 24;
    localparam int OUT_PAD_W      = OUT_TDATA_W - TILE_W - POS_W;

    // Neighbor candidates per tile, in emission order
    localparam int NEIGHBOR_SLOTS = 6;
    localparam int SLOT_UP        = 0;
    localparam int SLOT_DOWN      = 1;
    localparam int SLOT_LEFT      = 2;
    localparam int SLOT_RIGHT     = 3;
    localparam int SLOT_DIAG_L    = 4;
    localparam int SLOT_DIAG_R    = 5;
    localparam int SLOT_SEL_W     = $clog2(NEIGHBOR_SLOTS);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(NEIGHBOR_SLOTS - 1);

    // Divider pipeline: quotient bits resolved per stage
    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = TILE_W / DIV_STAGES;

    // Board size limits and register reset values
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_COLUMNS = 256;
    localparam logic [REG_W-1:0] ROW_COUNT_RESET    = 9'd9;
    localparam logic [REG_W-1:0] COLUMN_COUNT_RESET = 9'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } t_reg_index;

endpackage

// ===== hw/rtl/hex_grid_neighbor_indices.sv =====
// ============================================================================
// hex_grid_neighbor_indices
// Neighbor index generator for a column-offset hex board (odd columns
// shifted down), streaming in and out.
// ============================================================================
// A tile index enters on the slave stream and is split into row and column
// by a four-stage pipelined restoring divider (four quotient bits per stage,
// divisor is the clamped column count). The next stage checks the six
// candidates (up, down, left, right, then the two diagonals on the side set
// by column parity) against the board and latches their linear indices;
// that emitter stage then sends one in-board neighbor per cycle (while the
// master stream is not stalled) through the output register, with its
// position and tlast on the final one. A tile with no neighbor on the board,
// or any tile while the column count is zero, yields one transfer with tuser
// (none_found) and tlast set and index zero. Tiles can enter every cycle
// unless stalled; the emitter, which sends a tile's results (1 to 6, six in
// the interior of the board) one at a time, sets the sustained rate. A tile
// passes the four divider stages, the emitter and the output register in turn.
// The board size registers may only be written while no tile is in flight.
// ============================================================================
module hex_grid_neighbor_indices
    import hgni_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] tile_index
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [15:0] neighbor_index,
                                                     // [18:16] neighbor_position,
                                                     // [23:19] zero
    output logic                   o_m_axis_tuser,   // [0] none_found
    output logic                   o_m_axis_tlast
);

    // Widths of the clamped board sizes
    localparam int REG_MAX = (1 << REG_W) - 1;
    localparam int ROW_W   = (MAX_ROWS >= REG_MAX) ? REG_W : $clog2(MAX_ROWS + 1);
    localparam int COL_W   = (MAX_COLUMNS >= REG_MAX) ? REG_W : $clog2(MAX_COLUMNS + 1);
    localparam int LAST_DV = DIV_STAGES - 1;

    typedef struct packed {
        logic [COL_W-1:0]  rem;
        logic [TILE_W-1:0] quo;   // dividend bits shift out, quotient bits shift in
    } t_div_word;

    // Resolve one stage worth of quotient bits.
    function automatic t_div_word div_steps(input t_div_word w, input logic [COL_W-1:0] d);
        t_div_word        v;
        logic [COL_W:0]   part;
        v = w;
        for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            part = {v.rem, v.quo[TILE_W-1]};
            if (part >= {1'b0, d}) begin
                part  = part - {1'b0, d};
                v.quo = {v.quo[TILE_W-2:0], 1'b1};
            end else begin
                v.quo = {v.quo[TILE_W-2:0], 1'b0};
            end
            v.rem = part[COL_W-1:0];
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and clamping
    // ------------------------------------------------------------------
    logic [REG_W-1:0] r_row_count;
    logic [REG_W-1:0] r_column_count;
    logic [ROW_W-1:0] rows_eff;
    logic [COL_W-1:0] cols_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROW_COUNT_RESET;
            r_column_count <= COLUMN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_ROW_COUNT:    r_row_count    <= i_cfg_wdata;
                REG_COLUMN_COUNT: r_column_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp to the board limits; values at or below the limit pass unchanged.
    assign rows_eff = (32'(r_row_count) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                          : ROW_W'(r_row_count);
    assign cols_eff = (32'(r_column_count) > 32'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                                : COL_W'(r_column_count);

    // ------------------------------------------------------------------
    // Divider pipeline: tile -> (row, column)
    // ------------------------------------------------------------------
    logic                r_dv_valid [DIV_STAGES];
    t_div_word           r_dv_word  [DIV_STAGES];
    logic [TILE_W-1:0]   r_dv_tile  [DIV_STAGES];
    t_div_word           dv_in      [DIV_STAGES];
    t_div_word           n_dv_word  [DIV_STAGES];
    logic                dv_up_valid[DIV_STAGES];
    logic [TILE_W-1:0]   dv_up_tile [DIV_STAGES];
    logic                dv_ready   [DIV_STAGES+1];
    logic                em_ready;

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                dv_in[k]       = '{rem: '0, quo: i_s_axis_tdata[TILE_W-1:0]};
                dv_up_valid[k] = i_s_axis_tvalid;
                dv_up_tile[k]  = i_s_axis_tdata[TILE_W-1:0];
            end else begin
                dv_in[k]       = r_dv_word[k-1];
                dv_up_valid[k] = r_dv_valid[k-1];
                dv_up_tile[k]  = r_dv_tile[k-1];
            end
            n_dv_word[k] = div_steps(dv_in[k], cols_eff);
        end
    end

    // Backpressure chain: a stage advances when empty or when its successor does.
    always_comb begin
        dv_ready[DIV_STAGES] = em_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            dv_ready[k] = !r_dv_valid[k] || dv_ready[k+1];
        end
    end

    assign o_s_axis_tready = dv_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (dv_ready[k]) begin
                    r_dv_valid[k] <= dv_up_valid[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (dv_ready[k] && dv_up_valid[k]) begin
                r_dv_word[k] <= n_dv_word[k];
                r_dv_tile[k] <= dv_up_tile[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Candidate check on the divider result
    // ------------------------------------------------------------------
    logic [TILE_W:0]         row_ext;
    logic [TILE_W:0]         rows_ext;
    logic [COL_W:0]          col_ext;
    logic [COL_W:0]          cols_ext;
    logic [COL_W-1:0]        col;
    logic [TILE_W-1:0]       tile;
    logic [TILE_W-1:0]       cols16;
    logic [TILE_W-1:0]       off_diag_l;
    logic [TILE_W-1:0]       off_diag_r;
    logic                    col_odd;
    logic                    row_up_ok;
    logic                    row_dn_ok;
    logic                    row_same_ok;
    logic                    row_diag_ok;
    logic                    col_l_ok;
    logic                    col_r_ok;
    logic                    cols_ok;
    logic [NEIGHBOR_SLOTS-1:0] cand_mask;
    logic [TILE_W-1:0]       cand_idx [NEIGHBOR_SLOTS];

    always_comb begin
        tile     = r_dv_tile[LAST_DV];
        col      = r_dv_word[LAST_DV].rem;
        row_ext  = (TILE_W+1)'(r_dv_word[LAST_DV].quo);
        rows_ext = (TILE_W+1)'(rows_eff);
        col_ext  = (COL_W+1)'(col);
        cols_ext = (COL_W+1)'(cols_eff);
        cols16   = TILE_W'(cols_eff);
        col_odd  = col[0];
        cols_ok  = (cols_eff != '0);

        row_up_ok   = (row_ext != '0) && (row_ext <= rows_ext);
        row_dn_ok   = (row_ext + (TILE_W+1)'(1)) < rows_ext;
        row_same_ok = row_ext < rows_ext;
        row_diag_ok = col_odd ? row_dn_ok : row_up_ok;
        col_l_ok    = (col != '0);
        col_r_ok    = (col_ext + (COL_W+1)'(1)) < cols_ext;

        cand_mask[SLOT_UP]     = cols_ok && row_up_ok;
        cand_mask[SLOT_DOWN]   = cols_ok && row_dn_ok;
        cand_mask[SLOT_LEFT]   = cols_ok && row_same_ok && col_l_ok;
        cand_mask[SLOT_RIGHT]  = cols_ok && row_same_ok && col_r_ok;
        cand_mask[SLOT_DIAG_L] = cols_ok && row_diag_ok && col_l_ok;
        cand_mask[SLOT_DIAG_R] = cols_ok && row_diag_ok && col_r_ok;

        // Diagonal offsets: odd column goes one row down, even one row up.
        off_diag_l = col_odd ? (cols16 - TILE_W'(1)) : ~cols16;
        off_diag_r = col_odd ? (cols16 + TILE_W'(1)) : (~cols16 + TILE_W'(2));

        cand_idx[SLOT_UP]     = tile - cols16;
        cand_idx[SLOT_DOWN]   = tile + cols16;
        cand_idx[SLOT_LEFT]   = tile - TILE_W'(1);
        cand_idx[SLOT_RIGHT]  = tile + TILE_W'(1);
        cand_idx[SLOT_DIAG_L] = tile + off_diag_l;
        cand_idx[SLOT_DIAG_R] = tile + off_diag_r;
    end

    // ------------------------------------------------------------------
    // Emitter: one result per cycle, unless the output stalls, out of the held candidate set
    // ------------------------------------------------------------------
    logic                      r_em_valid;
    logic [NEIGHBOR_SLOTS-1:0] r_em_mask;
    logic [TILE_W-1:0]         r_em_idx [NEIGHBOR_SLOTS];
    logic [POS_W-1:0]          r_em_pos;
    logic [SLOT_SEL_W-1:0]     em_sel;
    logic                      em_found;
    logic [NEIGHBOR_SLOTS-1:0] em_rest;
    logic                      em_none;
    logic                      em_last;
    logic                      emit_take;
    logic                      em_done;
    logic                      r_out_valid;
    logic [TILE_W-1:0]         r_out_idx;
    logic [POS_W-1:0]          r_out_pos;
    logic                      r_out_none;
    logic                      r_out_last;

    // Pick the lowest remaining candidate.
    always_comb begin
        em_sel   = '0;
        em_found = 1'b0;
        for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
            if (r_em_mask[i] && !em_found) begin
                em_sel   = SLOT_SEL_W'(i);
                em_found = 1'b1;
            end
        end
    end

    assign em_rest   = r_em_mask & ~(NEIGHBOR_SLOTS'(1) << em_sel);
    assign em_none   = (r_em_mask == '0);
    assign em_last   = em_none || (em_rest == '0);
    assign emit_take = r_em_valid && (!r_out_valid || i_m_axis_tready);
    assign em_done   = emit_take && em_last;
    assign em_ready  = !r_em_valid || em_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (em_ready) begin
                r_em_valid <= r_dv_valid[LAST_DV];
            end
            if (emit_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Load a fresh tile when the emitter is empty or the previous one sends its final result.
        if (em_ready) begin
            r_em_mask <= cand_mask;
            r_em_idx  <= cand_idx;
            r_em_pos  <= '0;
        end else if (emit_take) begin
            r_em_mask <= em_rest;
            r_em_pos  <= r_em_pos + POS_W'(1);
        end
        if (emit_take) begin
            r_out_idx  <= em_none ? '0 : r_em_idx[em_sel];
            r_out_pos  <= em_none ? '0 : r_em_pos;
            r_out_none <= em_none;
            r_out_last <= em_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_pos, r_out_idx};
    assign o_m_axis_tuser  = r_out_none;
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A none-found transfer is always the only, and so the last, one.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("none_found result without tlast");

    // Position never runs past the last neighbor slot.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_valid |-> r_em_pos <= POS_MAX)
        else $error("emitter position out of range");

    // A stalled emitter holds its candidate set.
    a_em_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_valid && !emit_take |=> r_em_valid && (r_em_mask == $past(r_em_mask)))
        else $error("emitter state changed while stalled");

    // Divider remainder stays below a nonzero divisor.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[LAST_DV] && (cols_eff != '0) |-> r_dv_word[LAST_DV].rem < cols_eff)
        else $error("divider remainder not below column count");

endmodule
